FILE: rtl/bft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bft_pkg: shared types and constants of the bidirectional flow table
// Result status codes, table entry layout, controller/datapath interface.
// ----------------------------------------------------------------------------
package bft_pkg;

    localparam logic [2:0] STAT_HIT     = 3'd0;
    localparam logic [2:0] STAT_NEW     = 3'd1;
    localparam logic [2:0] STAT_FULL    = 3'd2;
    localparam logic [2:0] STAT_KEEP    = 3'd3;
    localparam logic [2:0] STAT_EXPIRED = 3'd4;

    localparam int          TABLE_DEPTH   = 4096;
    localparam int          MS_PER_SEC    = 1000;
    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

    // result kinds chosen by the controller
    typedef logic [2:0] res_kind_t;
    localparam res_kind_t RES_HIT     = 3'd0;
    localparam res_kind_t RES_NEW     = 3'd1;
    localparam res_kind_t RES_FULL    = 3'd2;
    localparam res_kind_t RES_EMPTY   = 3'd3;
    localparam res_kind_t RES_KEPT    = 3'd4;
    localparam res_kind_t RES_EXPIRED = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [63:0] addrs;        // low_ip, high_ip
        logic [39:0] ports_proto;  // low port, high port, protocol
        logic [47:0] first_seen;
        logic [47:0] last_seen;
        logic [31:0] packets;
        logic [47:0] bytes;
    } entry_t;

    typedef struct packed {
        logic      load_req;
        logic      div_dur;
        logic      probe_init;
        logic      probe_next;
        logic      mem_rd;
        logic      clr_we;
        logic      wr_new;
        logic      wr_hit;
        logic      wr_free;
        logic      res_set;
        res_kind_t res_kind;
        logic      res_dur;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic req_sweep;
        logic sweep_oob;
        logic div_busy;
        logic rd_valid;
        logic rd_match;
        logic expired;
        logic probe_last;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

FILE: rtl/bft_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bft_datapath: flow table datapath
// Request registers, key hash, duration divider, table memory, result and
// output registers, timeout register.
// ----------------------------------------------------------------------------
module bft_datapath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire bft_pkg::cmd_t cmd,
    output bft_pkg::sts_t      sts,
    input  wire logic          cfg_valid,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          s_req_type,
    input  wire logic [31:0]   s_src_ip,
    input  wire logic [31:0]   s_dst_ip,
    input  wire logic [15:0]   s_src_port,
    input  wire logic [15:0]   s_dst_port,
    input  wire logic [7:0]    s_ip_protocol,
    input  wire logic [15:0]   s_pkt_len,
    input  wire logic [47:0]   s_now_ms,
    input  wire logic [11:0]   s_sweep_slot,
    input  wire logic          m_ready,
    output logic               m_valid,
    output logic [2:0]         m_status,
    output logic [11:0]        m_slot_index,
    output logic [31:0]        m_flow_packets,
    output logic [47:0]        m_flow_bytes,
    output logic [31:0]        m_low_ip,
    output logic [31:0]        m_high_ip,
    output logic [15:0]        m_low_side_port,
    output logic [15:0]        m_high_side_port,
    output logic [7:0]         m_flow_protocol,
    output logic [31:0]        m_duration_sec
);
    import bft_pkg::*;

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_DEPTH - 1);

    // request
    logic        sweep_reg;
    logic [31:0] low_ip_reg, high_ip_reg;
    logic [15:0] low_port_reg, high_port_reg;
    logic [7:0]  proto_reg;
    logic [15:0] len_reg;
    logic [47:0] now_reg;
    logic [11:0] sslot_reg;
    logic [31:0] timeout_reg;

    logic swap;
    assign swap = (s_src_ip > s_dst_ip) || (s_src_ip == s_dst_ip && s_src_port > s_dst_port);

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            sweep_reg     <= s_req_type;
            low_ip_reg    <= swap ? s_dst_ip : s_src_ip;
            high_ip_reg   <= swap ? s_src_ip : s_dst_ip;
            low_port_reg  <= swap ? s_dst_port : s_src_port;
            high_port_reg <= swap ? s_src_port : s_dst_port;
            proto_reg     <= s_ip_protocol;
            len_reg       <= s_pkt_len;
            now_reg       <= s_now_ms;
            sslot_reg     <= s_sweep_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            timeout_reg <= cfg_data;
        end
    end

    logic [31:0] hash;
    assign hash = low_ip_reg ^ high_ip_reg ^ {low_port_reg, 16'd0} ^ {16'd0, high_port_reg}
                ^ {24'd0, proto_reg};

    logic [63:0] key_addrs;
    logic [39:0] key_pp;
    assign key_addrs = {low_ip_reg, high_ip_reg};
    assign key_pp    = {low_port_reg, high_port_reg, proto_reg};

    // table memory
    entry_t mem [TABLE_DEPTH];
    entry_t rd_reg;
    entry_t wd;
    logic [IDXW-1:0] wa, ra, sweep_idx;
    logic we;
    logic [IDXW-1:0] probe_reg, start_reg, cnt_reg, clr_cnt_reg;

    assign sweep_idx = IDXW'(sslot_reg);
    assign ra        = sweep_reg ? sweep_idx : probe_reg;
    assign we        = cmd.clr_we | cmd.wr_new | cmd.wr_hit | cmd.wr_free;

    logic [31:0] pk_new;
    logic [48:0] by_sum;
    logic [47:0] by_new, elapsed, span;
    assign pk_new  = (rd_reg.packets == 32'hFFFF_FFFF) ? rd_reg.packets : rd_reg.packets + 32'd1;
    assign by_sum  = {1'b0, rd_reg.bytes} + {33'd0, len_reg};
    assign by_new  = by_sum[48] ? 48'hFFFF_FFFF_FFFF : by_sum[47:0];
    assign elapsed = now_reg - rd_reg.last_seen;
    assign span    = rd_reg.last_seen - rd_reg.first_seen;

    always_comb begin
        wd = rd_reg;
        wa = probe_reg;
        if (cmd.clr_we) begin
            wd = '0;
            wa = clr_cnt_reg;
        end else if (cmd.wr_new) begin
            wd.valid       = 1'b1;
            wd.addrs       = key_addrs;
            wd.ports_proto = key_pp;
            wd.first_seen  = now_reg;
            wd.last_seen   = now_reg;
            wd.packets     = 32'd1;
            wd.bytes       = {32'd0, len_reg};
        end else if (cmd.wr_hit) begin
            wd.last_seen = now_reg;
            wd.packets   = pk_new;
            wd.bytes     = by_new;
        end else if (cmd.wr_free) begin
            wd.valid = 1'b0;
            wa       = sweep_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (cmd.mem_rd) begin
            rd_reg <= mem[ra];
        end
    end

    // span / 1000 in three 16-bit digits, high digit first: each digit is a
    // reciprocal multiply, the remainder update follows on the next cycle
    localparam logic [52:0] DIV_MAGIC = 53'd68719477;  // ceil(2^36 / 1000)

    logic [47:0] div_dvd_reg, div_q_reg;
    logic [9:0]  div_rem_reg;
    logic [15:0] div_digit_reg;
    logic [2:0]  div_cnt_reg;
    logic        div_busy_reg;
    logic [25:0] div_t, div_rem_full;
    logic [52:0] div_prod;

    assign div_t        = {div_rem_reg, div_dvd_reg[47:32]};
    assign div_prod     = 53'(div_t) * DIV_MAGIC;
    assign div_rem_full = div_t - 26'(div_digit_reg) * 26'(MS_PER_SEC);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (cmd.div_dur) begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end else if (div_busy_reg) begin
            div_cnt_reg <= div_cnt_reg + 3'd1;
            if (div_cnt_reg == 3'd5) begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_dur) begin
            div_dvd_reg <= span;
            div_rem_reg <= '0;
            div_q_reg   <= '0;
        end else if (div_busy_reg) begin
            if (!div_cnt_reg[0]) begin
                div_digit_reg <= div_prod[51:36];
            end else begin
                div_rem_reg <= div_rem_full[9:0];
                div_q_reg   <= {div_q_reg[31:0], div_digit_reg};
                div_dvd_reg <= {div_dvd_reg[31:0], 16'd0};
            end
        end
    end

    // probe and clear counters
    logic [IDXW-1:0] start_slot;
    assign start_slot = hash[IDXW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg   <= '0;
            cnt_reg     <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.probe_init) begin
                probe_reg <= start_slot;
                cnt_reg   <= '0;
            end else if (cmd.probe_next) begin
                probe_reg <= (probe_reg == LAST_IDX) ? '0 : probe_reg + 1'b1;
                cnt_reg   <= cnt_reg + 1'b1;
            end
            if (cmd.clr_we) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.probe_init) begin
            start_reg <= start_slot;
        end
    end

    // result
    logic [2:0]  res_status_reg;
    logic [11:0] res_slot_reg;
    logic [31:0] res_pk_reg, res_dur_reg;
    logic [47:0] res_by_reg;
    logic [63:0] res_addrs_reg;
    logic [39:0] res_pp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            res_dur_reg <= '0;
            case (cmd.res_kind)
                RES_HIT: begin
                    res_status_reg <= STAT_HIT;
                    res_slot_reg   <= 12'(probe_reg);
                    res_pk_reg     <= pk_new;
                    res_by_reg     <= by_new;
                    res_addrs_reg  <= key_addrs;
                    res_pp_reg     <= key_pp;
                end
                RES_NEW: begin
                    res_status_reg <= STAT_NEW;
                    res_slot_reg   <= 12'(probe_reg);
                    res_pk_reg     <= 32'd1;
                    res_by_reg     <= {32'd0, len_reg};
                    res_addrs_reg  <= key_addrs;
                    res_pp_reg     <= key_pp;
                end
                RES_FULL: begin
                    res_status_reg <= STAT_FULL;
                    res_slot_reg   <= 12'(start_reg);
                    res_pk_reg     <= '0;
                    res_by_reg     <= '0;
                    res_addrs_reg  <= key_addrs;
                    res_pp_reg     <= key_pp;
                end
                RES_KEPT, RES_EXPIRED: begin
                    res_status_reg <= (cmd.res_kind == RES_EXPIRED) ? STAT_EXPIRED : STAT_KEEP;
                    res_slot_reg   <= sslot_reg;
                    res_pk_reg     <= rd_reg.packets;
                    res_by_reg     <= rd_reg.bytes;
                    res_addrs_reg  <= rd_reg.addrs;
                    res_pp_reg     <= rd_reg.ports_proto;
                end
                default: begin
                    res_status_reg <= STAT_KEEP;
                    res_slot_reg   <= sslot_reg;
                    res_pk_reg     <= '0;
                    res_by_reg     <= '0;
                    res_addrs_reg  <= '0;
                    res_pp_reg     <= '0;
                end
            endcase
        end else if (cmd.res_dur) begin
            res_dur_reg <= (div_q_reg[47:32] != 16'd0) ? 32'hFFFF_FFFF : div_q_reg[31:0];
        end
    end

    // output register
    logic m_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status         <= res_status_reg;
            m_slot_index     <= res_slot_reg;
            m_flow_packets   <= res_pk_reg;
            m_flow_bytes     <= res_by_reg;
            m_low_ip         <= res_addrs_reg[63:32];
            m_high_ip        <= res_addrs_reg[31:0];
            m_low_side_port  <= res_pp_reg[39:24];
            m_high_side_port <= res_pp_reg[23:8];
            m_flow_protocol  <= res_pp_reg[7:0];
            m_duration_sec   <= res_dur_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        sts.req_sweep  = sweep_reg;
        sts.sweep_oob  = 32'(sslot_reg) >= TABLE_DEPTH;
        sts.div_busy   = div_busy_reg;
        sts.rd_valid   = rd_reg.valid;
        sts.rd_match   = (rd_reg.addrs == key_addrs) && (rd_reg.ports_proto == key_pp);
        sts.expired    = elapsed > {16'd0, timeout_reg};
        sts.probe_last = cnt_reg == LAST_IDX;
        sts.clr_last   = clr_cnt_reg == LAST_IDX;
        sts.out_free   = !m_valid_reg || m_ready;
    end

endmodule
`default_nettype wire

FILE: rtl/bft_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bft_ctrl: flow table controller
// Sequences the clearing pass, probing, sweep checks and result delivery.
// ----------------------------------------------------------------------------
module bft_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire bft_pkg::sts_t sts,
    output bft_pkg::cmd_t      cmd
);
    import bft_pkg::*;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_HASH    = 4'd2;
    localparam logic [3:0] S_PREAD   = 4'd4;
    localparam logic [3:0] S_PEVAL   = 4'd5;
    localparam logic [3:0] S_SREAD   = 4'd6;
    localparam logic [3:0] S_SEVAL   = 4'd7;
    localparam logic [3:0] S_DWAIT   = 4'd8;
    localparam logic [3:0] S_DELIVER = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_HASH;
                end
            end
            S_HASH: begin
                if (sts.req_sweep) begin
                    state_next = S_SREAD;
                end else begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_PREAD;
                end
            end
            S_PREAD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_PEVAL;
            end
            S_PEVAL: begin
                cmd.res_set = 1'b1;
                state_next  = S_DELIVER;
                if (!sts.rd_valid) begin
                    cmd.wr_new   = 1'b1;
                    cmd.res_kind = RES_NEW;
                end else if (sts.rd_match) begin
                    cmd.wr_hit   = 1'b1;
                    cmd.res_kind = RES_HIT;
                end else if (sts.probe_last) begin
                    cmd.res_kind = RES_FULL;
                end else begin
                    cmd.res_set    = 1'b0;
                    cmd.probe_next = 1'b1;
                    state_next     = S_PREAD;
                end
            end
            S_SREAD: begin
                if (sts.sweep_oob) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_EMPTY;
                    state_next   = S_DELIVER;
                end else begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_SEVAL;
                end
            end
            S_SEVAL: begin
                cmd.res_set = 1'b1;
                state_next  = S_DELIVER;
                if (!sts.rd_valid) begin
                    cmd.res_kind = RES_EMPTY;
                end else if (sts.expired) begin
                    cmd.res_kind = RES_EXPIRED;
                    cmd.wr_free  = 1'b1;
                    cmd.div_dur  = 1'b1;
                    state_next   = S_DWAIT;
                end else begin
                    cmd.res_kind = RES_KEPT;
                end
            end
            S_DWAIT: begin
                if (!sts.div_busy) begin
                    cmd.res_dur = 1'b1;
                    state_next  = S_DELIVER;
                end
            end
            S_DELIVER: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // the table is only written while a request is being worked on or during the clearing pass
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !(cmd.wr_new || cmd.wr_hit || cmd.wr_free || cmd.clr_we))
        else $error("table write while idle");

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.wr_new, cmd.wr_hit, cmd.wr_free, cmd.clr_we}))
        else $error("more than one table write source");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an undelivered one");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("request accepted during clearing pass");
`endif

endmodule
`default_nettype wire

FILE: rtl/bidirectional_flow_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bidirectional_flow_table: five-tuple flow table with linear probing
// Counts packets and bytes per bidirectional flow and expires idle flows.
// ----------------------------------------------------------------------------
// Usage:
//  s_* channel: one request per handshake. req_type 0 looks up or inserts
//  the packet's flow, req_type 1 checks one table slot for expiry.
//  m_* channel: exactly one result per request, in request order.
//  cfg_* channel: writes idle_timeout_ms; always ready, write only when idle.
// Sequence: a packet request goes from accept through the hash state, then
//  one memory read plus one compare per slot probed, then result delivery.
//  A sweep reads and checks its slot, and waits for the /1000 when it expires.
//  One request is worked on at a time; the next is taken once the result
//  sits in the output register, even while that result is still stalled.
// Reset: a clearing pass over all TABLE_DEPTH slots marks every slot empty;
//  s_ready stays low until it ends. A stalled m_ready holds the result and
//  the block waits after finishing its next request.
// ----------------------------------------------------------------------------
module bidirectional_flow_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [31:0] s_src_ip,
    input  wire logic [31:0] s_dst_ip,
    input  wire logic [15:0] s_src_port,
    input  wire logic [15:0] s_dst_port,
    input  wire logic [7:0]  s_ip_protocol,
    input  wire logic [15:0] s_pkt_len,
    input  wire logic [47:0] s_now_ms,
    input  wire logic [11:0] s_sweep_slot,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [11:0]      m_slot_index,
    output logic [31:0]      m_flow_packets,
    output logic [47:0]      m_flow_bytes,
    output logic [31:0]      m_low_ip,
    output logic [31:0]      m_high_ip,
    output logic [15:0]      m_low_side_port,
    output logic [15:0]      m_high_side_port,
    output logic [7:0]       m_flow_protocol,
    output logic [31:0]      m_duration_sec
);
    import bft_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bft_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .s_req_type       (s_req_type),
        .s_src_ip         (s_src_ip),
        .s_dst_ip         (s_dst_ip),
        .s_src_port       (s_src_port),
        .s_dst_port       (s_dst_port),
        .s_ip_protocol    (s_ip_protocol),
        .s_pkt_len        (s_pkt_len),
        .s_now_ms         (s_now_ms),
        .s_sweep_slot     (s_sweep_slot),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_status         (m_status),
        .m_slot_index     (m_slot_index),
        .m_flow_packets   (m_flow_packets),
        .m_flow_bytes     (m_flow_bytes),
        .m_low_ip         (m_low_ip),
        .m_high_ip        (m_high_ip),
        .m_low_side_port  (m_low_side_port),
        .m_high_side_port (m_high_side_port),
        .m_flow_protocol  (m_flow_protocol),
        .m_duration_sec   (m_duration_sec)
    );

endmodule
`default_nettype wire

FILE: tb/bft_checker.sv
// ----------------------------------------------------------------------------
// bft_checker: result predictor and scoreboard for the flow table
// Watches the config, request and result channels, keeps its own copy of
// the table, and compares each result field by field in request order.
// ----------------------------------------------------------------------------
module bft_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_req_type,
    input  wire logic [31:0] s_src_ip,
    input  wire logic [31:0] s_dst_ip,
    input  wire logic [15:0] s_src_port,
    input  wire logic [15:0] s_dst_port,
    input  wire logic [7:0]  s_ip_protocol,
    input  wire logic [15:0] s_pkt_len,
    input  wire logic [47:0] s_now_ms,
    input  wire logic [11:0] s_sweep_slot,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [2:0]  m_status,
    input  wire logic [11:0] m_slot_index,
    input  wire logic [31:0] m_flow_packets,
    input  wire logic [47:0] m_flow_bytes,
    input  wire logic [31:0] m_low_ip,
    input  wire logic [31:0] m_high_ip,
    input  wire logic [15:0] m_low_side_port,
    input  wire logic [15:0] m_high_side_port,
    input  wire logic [7:0]  m_flow_protocol,
    input  wire logic [31:0] m_duration_sec,
    output int               fail_count,
    output int               pending_results
);
    import bft_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] slot;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [31:0] low_ip;
        logic [31:0] high_ip;
        logic [15:0] low_port;
        logic [15:0] high_port;
        logic [7:0]  proto;
        logic [31:0] duration;
    } flow_result_t;

    entry_t       flow_table [TABLE_DEPTH];
    logic [31:0]  timeout_ms;
    flow_result_t expected_results [$];

    assign pending_results = expected_results.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic flow_result_t slot_result(input logic [2:0] st, input int s,
                                                 input logic [31:0] dur);
        flow_result_t r;
        r.status    = st;
        r.slot      = s[11:0];
        r.packets   = flow_table[s].packets;
        r.bytes     = flow_table[s].bytes;
        r.low_ip    = flow_table[s].addrs[63:32];
        r.high_ip   = flow_table[s].addrs[31:0];
        r.low_port  = flow_table[s].ports_proto[39:24];
        r.high_port = flow_table[s].ports_proto[23:8];
        r.proto     = flow_table[s].ports_proto[7:0];
        r.duration  = dur;
        return r;
    endfunction

    function automatic flow_result_t track_request();
        flow_result_t r;
        logic [31:0]  ip_a, ip_b, hash;
        logic [15:0]  pt_a, pt_b;
        logic [63:0]  addrs;
        logic [39:0]  pp;
        logic [47:0]  idle, span;
        logic [48:0]  sum;
        int           s, start;
        r = '0;
        if (s_req_type) begin
            s = s_sweep_slot;
            r.slot = s_sweep_slot;
            r.status = STAT_KEEP;
            if (s >= TABLE_DEPTH || !flow_table[s].valid) return r;
            idle = s_now_ms - flow_table[s].last_seen;
            if (idle > {16'd0, timeout_ms}) begin
                span = flow_table[s].last_seen - flow_table[s].first_seen;
                span = span / MS_PER_SEC;
                r = slot_result(STAT_EXPIRED, s,
                                (span > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0]);
                flow_table[s].valid = 1'b0;
            end else begin
                r = slot_result(STAT_KEEP, s, 32'd0);
            end
            return r;
        end
        ip_a = s_src_ip; ip_b = s_dst_ip; pt_a = s_src_port; pt_b = s_dst_port;
        if (ip_a > ip_b || (ip_a == ip_b && pt_a > pt_b)) begin
            ip_a = s_dst_ip; ip_b = s_src_ip; pt_a = s_dst_port; pt_b = s_src_port;
        end
        addrs = {ip_a, ip_b};
        pp = {pt_a, pt_b, s_ip_protocol};
        hash = ip_a ^ ip_b ^ {pt_a, 16'd0} ^ {16'd0, pt_b} ^ {24'd0, s_ip_protocol};
        start = hash % TABLE_DEPTH;
        s = start;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (!flow_table[s].valid) begin
                flow_table[s].valid = 1'b1;
                flow_table[s].addrs = addrs;
                flow_table[s].ports_proto = pp;
                flow_table[s].first_seen = s_now_ms;
                flow_table[s].last_seen = s_now_ms;
                flow_table[s].packets = 32'd1;
                flow_table[s].bytes = {32'd0, s_pkt_len};
                return slot_result(STAT_NEW, s, 32'd0);
            end
            if (flow_table[s].addrs == addrs && flow_table[s].ports_proto == pp) begin
                flow_table[s].last_seen = s_now_ms;
                if (flow_table[s].packets != 32'hFFFF_FFFF)
                    flow_table[s].packets++;
                sum = flow_table[s].bytes + s_pkt_len;
                flow_table[s].bytes = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
                return slot_result(STAT_HIT, s, 32'd0);
            end
            s = (s + 1) % TABLE_DEPTH;
        end
        r.status = STAT_FULL;
        r.slot = start[11:0];
        r.low_ip = ip_a; r.high_ip = ip_b;
        r.low_port = pt_a; r.high_port = pt_b; r.proto = s_ip_protocol;
        return r;
    endfunction

    initial begin
        fail_count = 0;
        timeout_ms = TIMEOUT_RESET;
        foreach (flow_table[i]) flow_table[i] = '0;
    end

    always @(posedge aclk) begin
        flow_result_t want;
        if (!aresetn) begin
            timeout_ms <= TIMEOUT_RESET;
        end else begin
            if (cfg_valid && cfg_ready) timeout_ms <= cfg_data;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", {61'd0, m_status}, 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_status != want.status) report("status", m_status, want.status);
                    if (m_slot_index != want.slot) report("slot", m_slot_index, want.slot);
                    if (m_flow_packets != want.packets)
                        report("packets", m_flow_packets, want.packets);
                    if (m_flow_bytes != want.bytes) report("bytes", m_flow_bytes, want.bytes);
                    if (m_low_ip != want.low_ip) report("low_ip", m_low_ip, want.low_ip);
                    if (m_high_ip != want.high_ip) report("high_ip", m_high_ip, want.high_ip);
                    if (m_low_side_port != want.low_port)
                        report("low port", m_low_side_port, want.low_port);
                    if (m_high_side_port != want.high_port)
                        report("high port", m_high_side_port, want.high_port);
                    if (m_flow_protocol != want.proto)
                        report("protocol", m_flow_protocol, want.proto);
                    if (m_duration_sec != want.duration)
                        report("duration", m_duration_sec, want.duration);
                end
            end
            if (s_valid && s_ready) expected_results.push_back(track_request());
        end
    end

    final begin
        if (expected_results.size() != 0)
            $display("%0d results never arrived", expected_results.size());
    end
endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the bidirectional flow table
// Directed corner requests, then random flow traffic with sweeps, bursty
// sender, stalling receiver, and several idle-timeout settings.
// ----------------------------------------------------------------------------
module tb_top;
    import bft_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 2_000_000;
    localparam bit  REQ_PACKET  = 1'b0;
    localparam bit  REQ_SWEEP   = 1'b1;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic [31:0] s_src_ip = '0, s_dst_ip = '0;
    logic [15:0] s_src_port = '0, s_dst_port = '0, s_pkt_len = '0;
    logic [7:0]  s_ip_protocol = '0;
    logic [47:0] s_now_ms = '0;
    logic [11:0] s_sweep_slot = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [11:0] m_slot_index;
    logic [31:0] m_flow_packets, m_low_ip, m_high_ip, m_duration_sec;
    logic [47:0] m_flow_bytes;
    logic [15:0] m_low_side_port, m_high_side_port;
    logic [7:0]  m_flow_protocol;
    int          fail_count, pending_results;
    int          cycles = 0;
    bit          hold_off = 1'b0;
    logic [47:0] clock_ms = 48'd1000;

    // a small pool of flows so hits, collisions and expiries happen often
    logic [31:0] pool_ip   [16];
    logic [15:0] pool_port [16];

    initial forever #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    bidirectional_flow_table uut (.*);

    bft_checker checker_i (.*);

    // receiver: random stall pattern, plus a long hold-off on request
    initial begin
        int run;
        forever begin
            run = $urandom_range(1, 30);
            case ($urandom_range(0, 2))
                0: begin
                    repeat (run) begin
                        @(posedge aclk);
                        m_ready <= !hold_off;
                    end
                end
                1: begin
                    repeat (run) begin
                        @(posedge aclk);
                        m_ready <= !hold_off && ($urandom_range(0, 3) != 0);
                    end
                end
                default: begin
                    repeat (run) begin
                        @(posedge aclk);
                        m_ready <= !hold_off && ($urandom_range(0, 3) == 0);
                    end
                end
            endcase
        end
    end

    task automatic send(input bit kind, input logic [31:0] a, input logic [31:0] b,
                        input logic [15:0] pa, input logic [15:0] pb, input logic [7:0] pr,
                        input logic [15:0] len, input logic [47:0] now,
                        input logic [11:0] slot);
        @(posedge aclk);
        s_valid <= 1'b1;
        s_req_type <= kind;
        s_src_ip <= a; s_dst_ip <= b;
        s_src_port <= pa; s_dst_port <= pb;
        s_ip_protocol <= pr; s_pkt_len <= len;
        s_now_ms <= now; s_sweep_slot <= slot;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
    endtask

    task automatic send_pool_packet(input logic [47:0] now);
        int i, j;
        i = $urandom_range(0, 15);
        j = $urandom_range(0, 15);
        send(REQ_PACKET, pool_ip[i], pool_ip[j], pool_port[i], pool_port[j],
             ($urandom_range(0, 1) ? 8'd6 : 8'd17), $urandom, now, $urandom);
    endtask

    task automatic drain_and_config(input logic [31:0] value);
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int gap;
        for (int n = 0; n < count; n++) begin
            clock_ms = clock_ms + $urandom_range(0, 3000);
            case ($urandom_range(0, 9))
                0: send(REQ_PACKET, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, {$urandom, $urandom} , $urandom);
                1, 2: send(REQ_SWEEP, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, clock_ms, pool_ip[$urandom_range(0, 15)] ^
                           pool_ip[$urandom_range(0, 15)] ^ $urandom_range(0, 3));
                3: send(REQ_SWEEP, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, clock_ms + $urandom_range(0, 100000), $urandom);
                default: send_pool_packet(clock_ms);
            endcase
            // bursts: mostly back-to-back, sometimes a gap
            if ($urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 20);
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin
        foreach (pool_ip[i]) begin
            pool_ip[i] = (i < 4) ? {20'hC0A80, i[11:0]} : $urandom;
            pool_port[i] = (i == 0) ? 16'd0 : (i == 1) ? 16'hFFFF : $urandom;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners
        send(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 0, 12'd0);
        send(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 12'hFFF);
        send(REQ_PACKET, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 16'd0, 8'hFF, 16'hFFFF,
             48'hFFFF_FFFF_FFF0, 0);
        send(REQ_PACKET, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, 8'hFF, 16'hFFFF,
             48'd5, 0);
        send(REQ_PACKET, 32'h0A000001, 32'h0A000001, 16'd80, 16'd10, 8'd6, 0, 48'd100, 0);
        send(REQ_PACKET, 32'h0A000001, 32'h0A000001, 16'd10, 16'd80, 8'd6, 16'd1, 48'd200, 0);
        send(REQ_PACKET, 32'h0A000001, 32'h0A000001, 16'd10, 16'd80, 8'd17, 16'd1, 48'd200, 0);
        // collision: same hash, different key -> probes to the next slot
        send(REQ_PACKET, 32'h00000001, 32'h00000002, 16'd0, 16'd0, 8'd0, 16'd9, 48'd300, 0);
        send(REQ_PACKET, 32'h00000000, 32'h00000003, 16'd0, 16'd0, 8'd0, 16'd9, 48'd300, 0);
        // sweep kept, expired, then found empty; then a flow expired with wrapped time
        send(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 48'd400, 12'd3);
        send(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 48'd400000, 12'd3);
        send(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 48'd400000, 12'd3);
        send(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 48'd40000, 12'h0FF);
        drain_and_config(32'd0);
        // timeout 0 (any nonzero idle time expires); the sweeps read slot 0x70C, the packet went to 0x408
        send(REQ_PACKET, 32'h01020304, 32'h05060708, 16'd1, 16'd2, 8'd6, 16'd50, 48'd7000, 0);
        send(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 48'd7000, 12'h70C);
        send(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 48'd7001, 12'h70C);

        drain_and_config(32'hFFFF_FFFF);
        random_phase(300);

        // pressure: receiver holds off while the sender keeps offering
        fork
            begin
                @(posedge aclk);
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_phase(40);
        join

        drain_and_config(32'd30000);
        random_phase(500);
        drain_and_config(32'd500);
        random_phase(400);
        drain_and_config(32'd0);
        random_phase(250);

        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
